[hw/rtl/rse_pkg.sv]
// Shared types, codes and widths for the randomized set engine.
`timescale 1ns / 1ps

package rse_pkg;

   localparam int DEF_CAPACITY = 64;
   localparam int VALUE_W      = 32;
   localparam int RANDOM_W     = 16;
   localparam int LIVE_W       = 7;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;

   // status codes
   localparam logic [2:0] ST_DONE    = 3'd0;
   localparam logic [2:0] ST_PRESENT = 3'd1;
   localparam logic [2:0] ST_ABSENT  = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;

   typedef struct packed {
      logic [1:0]                 operation;
      logic signed [VALUE_W-1:0]  item_value;
      logic [RANDOM_W-1:0]        random_word;
   } req_type;

   typedef struct packed {
      logic [2:0]                 status;
      logic signed [VALUE_W-1:0]  sampled_value;
      logic [LIVE_W-1:0]          live_count;
   } rsp_type;

endpackage

[hw/rtl/rse_store.sv]
// Element store: single-port-write, single-port-read memory, registered read data.
`timescale 1ns / 1ps

module rse_store #(
   parameter int CAPACITY = rse_pkg::DEF_CAPACITY
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
   input  logic [rse_pkg::VALUE_W-1:0]                 wr_data,
   input  logic                                        rd_en,
   input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
   output logic [rse_pkg::VALUE_W-1:0]                 rd_data
);

   logic [rse_pkg::VALUE_W-1:0] mem [CAPACITY];
   logic [rse_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/rse_modulo.sv]
// Restoring remainder unit: random word mod live count, one quotient bit per cycle.
`timescale 1ns / 1ps

module rse_modulo #(
   parameter int CAPACITY = rse_pkg::DEF_CAPACITY
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [rse_pkg::RANDOM_W-1:0]            dividend,
   input  logic [$clog2(CAPACITY+1)-1:0]           divisor,
   output logic                                    busy,
   output logic [$clog2(CAPACITY+1)-1:0]           remainder
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int DVD_W  = rse_pkg::RANDOM_W;
   localparam int STEP_W = $clog2(DVD_W);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DVD_W - 1);
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so one subtract per bit
         rem_in = (trial >= {1'b0, dsr_ff}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

[hw/rtl/rse_ctrl.sv]
// Operation sequencer: search, append, move-last-into-hole and sample over the store.
`timescale 1ns / 1ps

module rse_ctrl #(
   parameter int CAPACITY = rse_pkg::DEF_CAPACITY
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   input  rse_pkg::req_type                            req_word,
   output logic                                        busy,
   input  logic                                        out_free,
   output logic                                        res_valid,
   output rse_pkg::rsp_type                            res_word,
   output logic [$clog2(CAPACITY+1)-1:0]               count,
   output logic                                        mem_rd_en,
   output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] mem_rd_addr,
   input  logic [rse_pkg::VALUE_W-1:0]                 mem_rd_data,
   output logic                                        mem_wr_en,
   output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] mem_wr_addr,
   output logic [rse_pkg::VALUE_W-1:0]                 mem_wr_data,
   output logic                                        div_start,
   output logic [rse_pkg::RANDOM_W-1:0]                div_dividend,
   output logic [$clog2(CAPACITY+1)-1:0]               div_divisor,
   input  logic                                        div_busy,
   input  logic [$clog2(CAPACITY+1)-1:0]               div_rem
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = CAPACITY > 1 ? $clog2(CAPACITY) : 1;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SEARCH  = 3'd1;
   localparam logic [2:0] S_RD_LAST = 3'd2;
   localparam logic [2:0] S_MOVE    = 3'd3;
   localparam logic [2:0] S_DIV     = 3'd4;
   localparam logic [2:0] S_RD_SAMP = 3'd5;
   localparam logic [2:0] S_FINISH  = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            scan_ff, scan_in;
   logic                        pend_ff, pend_in;
   logic [ADDR_W-1:0]           pend_idx_ff, pend_idx_in;
   logic [ADDR_W-1:0]           pos_ff, pos_in;
   logic [1:0]                  op_ff, op_in;
   logic [rse_pkg::VALUE_W-1:0] val_ff, val_in;
   logic [2:0]                  status_ff, status_in;
   logic [rse_pkg::VALUE_W-1:0] samp_ff, samp_in;
   logic [CNT_W-1:0]            last_idx;
   logic                        hit;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      pos_in      = pos_ff;
      op_in       = op_ff;
      val_in      = val_ff;
      status_in   = status_ff;
      samp_in     = samp_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = scan_ff[ADDR_W-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = count_ff[ADDR_W-1:0];
      mem_wr_data = val_ff;
      div_start   = 1'b0;
      res_valid   = 1'b0;
      last_idx    = count_ff - 1'b1;
      hit         = pend_ff && (mem_rd_data == val_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_word.operation;
               val_in    = $unsigned(req_word.item_value);
               scan_in   = '0;
               status_in = rse_pkg::ST_DONE;
               samp_in   = '0;
               case (req_word.operation)
                  rse_pkg::OP_INSERT, rse_pkg::OP_REMOVE: begin
                     state_in = S_SEARCH;
                  end
                  rse_pkg::OP_SAMPLE: begin
                     if (count_ff == '0) begin
                        status_in = rse_pkg::ST_EMPTY;
                        state_in  = S_FINISH;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            // one read issued and one compare retired per cycle
            mem_rd_en   = scan_ff < count_ff;
            pend_in     = mem_rd_en;
            pend_idx_in = scan_ff[ADDR_W-1:0];
            if (mem_rd_en) begin
               scan_in = scan_ff + 1'b1;
            end
            if (hit) begin
               if (op_ff == rse_pkg::OP_INSERT) begin
                  status_in = rse_pkg::ST_PRESENT;
                  state_in  = S_FINISH;
               end else begin
                  pos_in   = pend_idx_ff;
                  state_in = S_RD_LAST;
               end
            end else if (!mem_rd_en && !pend_ff) begin
               state_in = S_FINISH;
               if (op_ff == rse_pkg::OP_INSERT) begin
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     status_in = rse_pkg::ST_FULL;
                  end else begin
                     mem_wr_en = 1'b1;
                     count_in  = count_ff + 1'b1;
                  end
               end else begin
                  status_in = rse_pkg::ST_ABSENT;
               end
            end
         end
         S_RD_LAST: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = last_idx[ADDR_W-1:0];
            state_in    = S_MOVE;
         end
         S_MOVE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_ff;
            mem_wr_data = mem_rd_data;
            count_in    = count_ff - 1'b1;
            state_in    = S_FINISH;
         end
         S_DIV: begin
            if (!div_busy) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = div_rem[ADDR_W-1:0];
               state_in    = S_RD_SAMP;
            end
         end
         S_RD_SAMP: begin
            samp_in  = mem_rd_data;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      pos_ff      <= pos_in;
      op_ff       <= op_in;
      val_ff      <= val_in;
      status_ff   <= status_in;
      samp_ff     <= samp_in;
   end

   assign busy                   = state_ff != S_IDLE;
   assign count                  = count_ff;
   assign div_dividend           = req_word.random_word;
   assign div_divisor            = count_ff;
   assign res_word.status        = status_ff;
   assign res_word.sampled_value = $signed(samp_ff);
   assign res_word.live_count    = rse_pkg::LIVE_W'(count_ff);

endmodule

[hw/rtl/randomized_set_engine.sv]
// Top level of the randomized set engine: sequencer, store, remainder unit, result register.
`timescale 1ns / 1ps

// Randomized set engine. Holds up to CAPACITY distinct signed 32-bit values packed
// densely in one synchronous memory, plus a live count. Each request word carries an
// operation: insert appends the value unless it is already present (status present) or
// the store is full (status full, presence checked first); remove finds the value, copies
// the last live entry into its slot and drops the count (status not present if absent);
// sample returns the live entry at index random_word mod count (status empty and value
// zero when the set is empty). Unused opcodes complete as a no-op with status done. Every
// request yields exactly one response word with the count after the operation, truncated
// to 7 bits. One request is in flight at a time: req_stall is high from acceptance until
// the response is loaded into the output register, which then waits for the consumer
// while the next request is accepted. Timing is set by the single memory read port:
// insert and remove scan the live entries one per cycle; a remove hit then reads the last
// entry and writes it into the hole. Sample runs a 16-step restoring remainder plus a
// memory read. The store needs no clearing after reset; only entries below the count are
// ever read.
module randomized_set_engine #(
   parameter int CAPACITY = rse_pkg::DEF_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rse_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rse_pkg::rsp_type rsp_word
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = CAPACITY > 1 ? $clog2(CAPACITY) : 1;

   logic                         busy;
   logic                         out_free;
   logic                         res_valid;
   rse_pkg::rsp_type             res_word;
   logic [CNT_W-1:0]             count;
   logic                         mem_rd_en;
   logic [ADDR_W-1:0]            mem_rd_addr;
   logic [rse_pkg::VALUE_W-1:0]  mem_rd_data;
   logic                         mem_wr_en;
   logic [ADDR_W-1:0]            mem_wr_addr;
   logic [rse_pkg::VALUE_W-1:0]  mem_wr_data;
   logic                         div_start;
   logic [rse_pkg::RANDOM_W-1:0] div_dividend;
   logic [CNT_W-1:0]             div_divisor;
   logic                         div_busy;
   logic [CNT_W-1:0]             div_rem;

   // output register: parts the sequencer from a stalled consumer
   logic             rsp_valid_ff, rsp_valid_in;
   rse_pkg::rsp_type rsp_word_ff;
   logic             load;

   rse_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_word     (req_word),
      .busy         (busy),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res_word     (res_word),
      .count        (count),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_busy     (div_busy),
      .div_rem      (div_rem)
   );

   // reads and writes never touch the same entry in one cycle: each write happens in a
   // state that issues no read, and the read it depends on completed the cycle before
   rse_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   rse_modulo #(
      .CAPACITY (CAPACITY)
   ) u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = res_valid && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_word_ff <= res_word;
      end
   end

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // an accepted request always leaves the sequencer busy in the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but sequencer not busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CNT_W'(CAPACITY))
      else $error("live count above capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == rse_pkg::ST_FULL) |->
         (rsp_word.live_count == rse_pkg::LIVE_W'(CAPACITY)))
      else $error("full reported with free entries");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status != rse_pkg::ST_DONE) |-> (rsp_word.sampled_value == '0))
      else $error("error response carries a sampled value");

endmodule
